/* src/tree_record_stream_parser_assert.svh */
// Assertion macros for the tree-listing parser.
`ifndef TREE_RECORD_STREAM_PARSER_ASSERT_SVH
`define TREE_RECORD_STREAM_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge out of reset.
`define TRP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");

// Next-cycle implication.
`define TRP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`else

`define TRP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TRP_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/trp_pkg.sv */
package trp_pkg;

	typedef enum logic [3:0] {
		PH_HEADER,
		PH_CODE,
		PH_STRING,
		PH_HEX1,
		PH_HEX2,
		PH_BRACKET,
		PH_KEYSTART,
		PH_NEWLINE
	} phase_t;

	localparam logic [1:0] ROLE_NAME  = 2'd0;
	localparam logic [1:0] ROLE_KEY   = 2'd1;
	localparam logic [1:0] ROLE_VALUE = 2'd2;

	localparam logic [1:0] KIND_ENTER = 2'd0;
	localparam logic [1:0] KIND_NODE  = 2'd1;
	localparam logic [1:0] KIND_MARK  = 2'd2;
	localparam logic [1:0] KIND_LEAVE = 2'd3;

	localparam logic [2:0] EV_START  = 3'd0;
	localparam logic [2:0] EV_NAME   = 3'd1;
	localparam logic [2:0] EV_KEY    = 3'd2;
	localparam logic [2:0] EV_VALUE  = 3'd3;
	localparam logic [2:0] EV_STREND = 3'd4;
	localparam logic [2:0] EV_RECEND = 3'd5;
	localparam logic [2:0] EV_ERROR  = 3'd6;

	localparam logic [2:0] ERR_HEADER = 3'd0;
	localparam logic [2:0] ERR_CODE   = 3'd1;
	localparam logic [2:0] ERR_CHAR   = 3'd2;
	localparam logic [2:0] ERR_HEX    = 3'd3;
	localparam logic [2:0] ERR_DEPTH  = 3'd4;

	localparam int HDR_LEN = 16;

	localparam logic [7:0] CH_ENTER   = 8'h64; // d
	localparam logic [7:0] CH_NODE    = 8'h66; // f
	localparam logic [7:0] CH_MARK    = 8'h2d; // -
	localparam logic [7:0] CH_LEAVE   = 8'h75; // u
	localparam logic [7:0] CH_OPEN    = 8'h5b; // [
	localparam logic [7:0] CH_CLOSE   = 8'h5d; // ]
	localparam logic [7:0] CH_ESCAPE  = 8'h3d; // =
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NEWLINE = 8'h0a;

	typedef struct packed {
		phase_t     phase;
		logic [3:0] hdr_idx;
		logic       closing;
		logic       finished;
		logic       failed;
		logic [3:0] hex_high;
		logic [1:0] role;
		logic [1:0] kind;
	} parse_state_t;

	typedef struct packed {
		logic       valid;
		logic [2:0] ev;
		logic [1:0] kind;
		logic [7:0] data;
		logic [2:0] err;
		logic       done;
	} result_t;

	function automatic logic [7:0] hdr_byte(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'h61;
			4'd1:    c = 8'h73;
			4'd2:    c = 8'h75;
			4'd3:    c = 8'h72;
			4'd4:    c = 8'h65;
			4'd5:    c = 8'h2d;
			4'd6:    c = 8'h32;
			4'd7:    c = 8'h2e;
			4'd8:    c = 8'h30;
			4'd9:    c = 8'h0a;
			4'd15:   c = 8'h0a;
			default: c = 8'h2d;
		endcase
		return c;
	endfunction

endpackage

/* src/tree_record_stream_parser.sv */
// Channel   Ports                                   Direction
// input     in_valid, in_stall, in_byte             byte stream in
// output    out_valid, out_stall, event_res,        parse events out
//           record_kind, data_byte, error_code,
//           tree_done, nesting_depth
//
// One byte is taken per cycle while the input is not stalled; its event, if any, passes from
// the input byte register into the event register. The per-byte parser step sits between them.
// Reset puts the parser back at the start of the header with depth zero.
// A stall on the output holds the event register, and the input stalls only when a
// byte is waiting in the input register behind it.

`include "tree_record_stream_parser_assert.svh"

module tree_record_stream_parser #(
	parameter int DEPTH_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_res,
	output logic [1:0]  record_kind,
	output logic [7:0]  data_byte,
	output logic [2:0]  error_code,
	output logic        tree_done,
	output logic [15:0] nesting_depth
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  advance;
	trp_pkg::parse_state_t state_q;
	trp_pkg::parse_state_t state_nxt;
	logic [DEPTH_BITS-1:0] nest_q;
	logic [DEPTH_BITS-1:0] nest_nxt;
	trp_pkg::result_t      res;
	logic [15:0]           res_depth;

	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: trp_pkg::PH_HEADER, default: '0};
			nest_q  <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
			nest_q  <= nest_nxt;
		end
	end

	trp_step #(
		.DEPTH_BITS (DEPTH_BITS)
	) u_step (
		.in_byte   (byte_s1),
		.cur       (state_q),
		.cur_nest  (nest_q),
		.nxt       (state_nxt),
		.nxt_nest  (nest_nxt),
		.res       (res),
		.res_depth (res_depth)
	);

	trp_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (valid_s1 && res.valid),
		.res           (res),
		.res_depth     (res_depth),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.room          (advance),
		.event_res     (event_res),
		.record_kind   (record_kind),
		.data_byte     (data_byte),
		.error_code    (error_code),
		.tree_done     (tree_done),
		.nesting_depth (nesting_depth)
	);

	`TRP_ASSERT_IMP(a_stall_has_byte, clk, arst_n, in_stall, valid_s1)
	`TRP_ASSERT_IMP(a_done_on_recend, clk, arst_n, out_valid && tree_done, event_res == trp_pkg::EV_RECEND)
	`TRP_ASSERT_IMP(a_quiet_after_end, clk, arst_n, state_q.failed || state_q.finished, !res.valid)
	`TRP_ASSERT_NXT(a_failure_sticks, clk, arst_n, state_q.failed, state_q.failed)

endmodule

/* src/trp_step.sv */
module trp_step #(
	parameter int DEPTH_BITS = 16
) (
	input  logic [7:0]            in_byte,
	input  trp_pkg::parse_state_t cur,
	input  logic [DEPTH_BITS-1:0] cur_nest,
	output trp_pkg::parse_state_t nxt,
	output logic [DEPTH_BITS-1:0] nxt_nest,
	output trp_pkg::result_t      res,
	output logic [15:0]           res_depth
);

	localparam int EXT_BITS = (DEPTH_BITS > 16) ? DEPTH_BITS : 16;
	localparam logic [DEPTH_BITS-1:0] NEST_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
	localparam logic [DEPTH_BITS-1:0] NEST_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

	logic       hex_ok;
	logic [3:0] hex_val;
	logic [EXT_BITS-1:0] depth_ext;

	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		case (in_byte) inside
			[8'h30:8'h39]: hex_val = 4'(in_byte - 8'h30);
			[8'h61:8'h66]: hex_val = 4'(in_byte - 8'h57);
			default: hex_ok = 1'b0;
		endcase
	end

	always_comb begin
		nxt      = cur;
		nxt_nest = cur_nest;
		res      = '0;
		res.kind = cur.kind;

		if (!(cur.failed || cur.finished)) begin
			case (cur.phase)
				trp_pkg::PH_HEADER: begin
					if (in_byte != trp_pkg::hdr_byte(cur.hdr_idx)) begin
						nxt.failed = 1'b1;
						res.valid  = 1'b1;
						res.ev     = trp_pkg::EV_ERROR;
						res.err    = trp_pkg::ERR_HEADER;
						res.data   = in_byte;
					end else begin
						nxt.hdr_idx = cur.hdr_idx + 4'd1;
						if (cur.hdr_idx == 4'(trp_pkg::HDR_LEN - 1)) begin
							nxt.phase = trp_pkg::PH_CODE;
						end
					end
				end
				trp_pkg::PH_CODE: begin
					res.valid = 1'b1;
					res.ev    = trp_pkg::EV_START;
					case (in_byte)
						trp_pkg::CH_ENTER: begin
							nxt.kind = trp_pkg::KIND_ENTER;
							if (cur_nest == NEST_MAX) begin
								nxt.failed = 1'b1;
								res.ev     = trp_pkg::EV_ERROR;
								res.err    = trp_pkg::ERR_DEPTH;
								res.data   = in_byte;
							end else begin
								nxt_nest  = cur_nest + 1'b1;
								nxt.role  = trp_pkg::ROLE_NAME;
								nxt.phase = trp_pkg::PH_STRING;
							end
						end
						trp_pkg::CH_NODE: begin
							nxt.kind  = trp_pkg::KIND_NODE;
							nxt.role  = trp_pkg::ROLE_NAME;
							nxt.phase = trp_pkg::PH_STRING;
						end
						trp_pkg::CH_MARK: begin
							nxt.kind  = trp_pkg::KIND_MARK;
							nxt.phase = trp_pkg::PH_NEWLINE;
						end
						trp_pkg::CH_LEAVE: begin
							nxt.kind = trp_pkg::KIND_LEAVE;
							if (cur_nest == NEST_MIN) begin
								nxt.failed = 1'b1;
								res.ev     = trp_pkg::EV_ERROR;
								res.err    = trp_pkg::ERR_DEPTH;
								res.data   = in_byte;
							end else begin
								nxt_nest    = cur_nest - 1'b1;
								nxt.closing = (cur_nest == DEPTH_BITS'(1));
								nxt.phase   = trp_pkg::PH_NEWLINE;
							end
						end
						default: begin
							nxt.failed = 1'b1;
							res.ev     = trp_pkg::EV_ERROR;
							res.err    = trp_pkg::ERR_CODE;
							res.data   = in_byte;
						end
					endcase
					// The start and depth-error results carry the kind just decoded; a bad code keeps the old kind.
					res.kind = nxt.kind;
				end
				trp_pkg::PH_STRING: begin
					if (in_byte == trp_pkg::CH_SPACE) begin
						res.valid = 1'b1;
						res.ev    = trp_pkg::EV_STREND;
						case (cur.role)
							trp_pkg::ROLE_NAME: nxt.phase = trp_pkg::PH_BRACKET;
							trp_pkg::ROLE_KEY:  nxt.role  = trp_pkg::ROLE_VALUE;
							default:            nxt.phase = trp_pkg::PH_KEYSTART;
						endcase
					end else if (in_byte == trp_pkg::CH_ESCAPE) begin
						nxt.phase = trp_pkg::PH_HEX1;
					end else begin
						res.valid = 1'b1;
						res.ev    = trp_pkg::EV_NAME + {1'b0, cur.role};
						res.data  = in_byte;
					end
				end
				trp_pkg::PH_HEX1: begin
					if (!hex_ok) begin
						nxt.failed = 1'b1;
						res.valid  = 1'b1;
						res.ev     = trp_pkg::EV_ERROR;
						res.err    = trp_pkg::ERR_HEX;
						res.data   = in_byte;
					end else begin
						nxt.hex_high = hex_val;
						nxt.phase    = trp_pkg::PH_HEX2;
					end
				end
				trp_pkg::PH_HEX2: begin
					res.valid = 1'b1;
					if (!hex_ok) begin
						nxt.failed = 1'b1;
						res.ev     = trp_pkg::EV_ERROR;
						res.err    = trp_pkg::ERR_HEX;
						res.data   = in_byte;
					end else begin
						nxt.phase = trp_pkg::PH_STRING;
						res.ev    = trp_pkg::EV_NAME + {1'b0, cur.role};
						res.data  = {cur.hex_high, hex_val};
					end
				end
				trp_pkg::PH_BRACKET: begin
					if (in_byte != trp_pkg::CH_OPEN) begin
						nxt.failed = 1'b1;
						res.valid  = 1'b1;
						res.ev     = trp_pkg::EV_ERROR;
						res.err    = trp_pkg::ERR_CHAR;
						res.data   = in_byte;
					end else begin
						nxt.phase = trp_pkg::PH_KEYSTART;
					end
				end
				trp_pkg::PH_KEYSTART: begin
					if (in_byte == trp_pkg::CH_CLOSE) begin
						nxt.phase = trp_pkg::PH_NEWLINE;
					end else begin
						// The first key byte is taken as it stands, escape or not.
						nxt.role  = trp_pkg::ROLE_KEY;
						nxt.phase = trp_pkg::PH_STRING;
						res.valid = 1'b1;
						res.ev    = trp_pkg::EV_KEY;
						res.data  = in_byte;
					end
				end
				trp_pkg::PH_NEWLINE: begin
					res.valid = 1'b1;
					if (in_byte != trp_pkg::CH_NEWLINE) begin
						nxt.failed = 1'b1;
						res.ev     = trp_pkg::EV_ERROR;
						res.err    = trp_pkg::ERR_CHAR;
						res.data   = in_byte;
					end else begin
						nxt.phase = trp_pkg::PH_CODE;
						res.ev    = trp_pkg::EV_RECEND;
						if (cur.closing) begin
							nxt.finished = 1'b1;
							nxt.closing  = 1'b0;
							res.done     = 1'b1;
						end
					end
				end
				default: begin
					nxt.failed = 1'b1;
					res.valid  = 1'b1;
					res.ev     = trp_pkg::EV_ERROR;
					res.err    = trp_pkg::ERR_CHAR;
					res.data   = in_byte;
				end
			endcase
		end
	end

	assign depth_ext = EXT_BITS'(signed'(nxt_nest));
	assign res_depth = depth_ext[15:0];

endmodule

/* src/trp_out_reg.sv */
module trp_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  trp_pkg::result_t res,
	input  logic [15:0]      res_depth,
	input  logic             out_stall,
	output logic             out_valid,
	output logic             room,
	output logic [2:0]       event_res,
	output logic [1:0]       record_kind,
	output logic [7:0]       data_byte,
	output logic [2:0]       error_code,
	output logic             tree_done,
	output logic [15:0]      nesting_depth
);

	logic valid_q;

	// The register can take a new result when it is empty or being drained.
	assign room      = !(valid_q && out_stall);
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (room && load) begin
			event_res     <= res.ev;
			record_kind   <= res.kind;
			data_byte     <= res.data;
			error_code    <= res.err;
			tree_done     <= res.done;
			nesting_depth <= res_depth;
		end
	end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;

	// A narrow depth keeps both overflow endings within a short run.
	localparam int DEPTH_W = 6;
	localparam logic signed [DEPTH_W-1:0] NEST_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
	localparam logic signed [DEPTH_W-1:0] NEST_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};
	localparam logic [7:0] HEADER_BYTES [trp_pkg::HDR_LEN] = '{
		8'h61, 8'h73, 8'h75, 8'h72, 8'h65, 8'h2d, 8'h32, 8'h2e,
		8'h30, 8'h0a, 8'h2d, 8'h2d, 8'h2d, 8'h2d, 8'h2d, 8'h0a
	};

	typedef enum int {
		END_TREE,
		END_BAD_CODE,
		END_BAD_BRACKET,
		END_BAD_NEWLINE,
		END_BAD_HEX,
		END_DEPTH_HIGH,
		END_DEPTH_LOW,
		END_BAD_HEADER
	} ending_t;

	typedef struct {
		logic [2:0]  ev;
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [2:0]  err;
		logic        done;
		logic [15:0] depth;
	} parse_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  event_res;
	logic [1:0]  record_kind;
	logic [7:0]  data_byte;
	logic [2:0]  error_code;
	logic        tree_done;
	logic [15:0] nesting_depth;

	logic [7:0]   byte_stream [$];
	parse_event_t pending_events [$];
	logic         byte_taken = 1'b0;
	logic         draining = 1'b0;
	int           accepted_bytes = 0;
	int           mismatches = 0;
	int           cycles = 0;
	int           cycle_limit = 32'h7fffffff;

	// Parser state as the block should hold it.
	trp_pkg::phase_t            phase = trp_pkg::PH_HEADER;
	int                         hdr_pos = 0;
	logic signed [DEPTH_W-1:0]  nest = '0;
	logic                       closing = 1'b0;
	logic                       finished = 1'b0;
	logic                       failed = 1'b0;
	logic [3:0]                 hex_hi = 4'd0;
	logic [1:0]                 role = trp_pkg::ROLE_NAME;
	logic [1:0]                 kind = trp_pkg::KIND_ENTER;

	tree_record_stream_parser #(.DEPTH_BITS(DEPTH_W)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_res(event_res),
		.record_kind(record_kind),
		.data_byte(data_byte),
		.error_code(error_code),
		.tree_done(tree_done),
		.nesting_depth(nesting_depth)
	);

	always #2 clk = ~clk;

	// Bit 4 set means the byte is not a lowercase hex digit.
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39)
			return {1'b0, 4'(c - 8'h30)};
		if (c >= 8'h61 && c <= 8'h66)
			return {1'b0, 4'(c - 8'h61 + 8'd10)};
		return 5'b10000;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h61 + 8'(n) - 8'd10;
	endfunction

	task automatic note(input logic [2:0] ev, input logic [7:0] data, input logic [2:0] err,
			input logic done);
		parse_event_t e;
		e.ev = ev;
		e.kind = kind;
		e.data = data;
		e.err = err;
		e.done = done;
		e.depth = 16'(nest);
		pending_events.push_back(e);
	endtask

	task automatic raise(input logic [2:0] code, input logic [7:0] b);
		failed = 1'b1;
		note(trp_pkg::EV_ERROR, b, code, 1'b0);
	endtask

	task automatic parse_byte(input logic [7:0] b);
		logic [4:0] h;
		if (failed || finished)
			return;
		case (phase)
			trp_pkg::PH_HEADER: begin
				if (b != HEADER_BYTES[hdr_pos]) begin
					raise(trp_pkg::ERR_HEADER, b);
				end else begin
					hdr_pos++;
					if (hdr_pos == trp_pkg::HDR_LEN)
						phase = trp_pkg::PH_CODE;
				end
			end
			trp_pkg::PH_CODE: begin
				if (b == trp_pkg::CH_ENTER) begin
					kind = trp_pkg::KIND_ENTER;
					if (nest == NEST_MAX) begin
						raise(trp_pkg::ERR_DEPTH, b);
					end else begin
						nest = nest + 1'b1;
						role = trp_pkg::ROLE_NAME;
						phase = trp_pkg::PH_STRING;
						note(trp_pkg::EV_START, 8'd0, 3'd0, 1'b0);
					end
				end else if (b == trp_pkg::CH_NODE) begin
					kind = trp_pkg::KIND_NODE;
					role = trp_pkg::ROLE_NAME;
					phase = trp_pkg::PH_STRING;
					note(trp_pkg::EV_START, 8'd0, 3'd0, 1'b0);
				end else if (b == trp_pkg::CH_MARK) begin
					kind = trp_pkg::KIND_MARK;
					phase = trp_pkg::PH_NEWLINE;
					note(trp_pkg::EV_START, 8'd0, 3'd0, 1'b0);
				end else if (b == trp_pkg::CH_LEAVE) begin
					kind = trp_pkg::KIND_LEAVE;
					if (nest == NEST_MIN) begin
						raise(trp_pkg::ERR_DEPTH, b);
					end else begin
						nest = nest - 1'b1;
						closing = (nest == 0);
						phase = trp_pkg::PH_NEWLINE;
						note(trp_pkg::EV_START, 8'd0, 3'd0, 1'b0);
					end
				end else begin
					raise(trp_pkg::ERR_CODE, b);
				end
			end
			trp_pkg::PH_STRING: begin
				if (b == trp_pkg::CH_SPACE) begin
					if (role == trp_pkg::ROLE_NAME)
						phase = trp_pkg::PH_BRACKET;
					else if (role == trp_pkg::ROLE_KEY)
						role = trp_pkg::ROLE_VALUE;
					else
						phase = trp_pkg::PH_KEYSTART;
					note(trp_pkg::EV_STREND, 8'd0, 3'd0, 1'b0);
				end else if (b == trp_pkg::CH_ESCAPE) begin
					phase = trp_pkg::PH_HEX1;
				end else begin
					note(3'(trp_pkg::EV_NAME + role), b, 3'd0, 1'b0);
				end
			end
			trp_pkg::PH_HEX1: begin
				h = hex_nibble(b);
				if (h[4]) begin
					raise(trp_pkg::ERR_HEX, b);
				end else begin
					hex_hi = h[3:0];
					phase = trp_pkg::PH_HEX2;
				end
			end
			trp_pkg::PH_HEX2: begin
				h = hex_nibble(b);
				if (h[4]) begin
					raise(trp_pkg::ERR_HEX, b);
				end else begin
					phase = trp_pkg::PH_STRING;
					note(3'(trp_pkg::EV_NAME + role), {hex_hi, h[3:0]}, 3'd0, 1'b0);
				end
			end
			trp_pkg::PH_BRACKET: begin
				if (b != trp_pkg::CH_OPEN)
					raise(trp_pkg::ERR_CHAR, b);
				else
					phase = trp_pkg::PH_KEYSTART;
			end
			trp_pkg::PH_KEYSTART: begin
				if (b == trp_pkg::CH_CLOSE) begin
					phase = trp_pkg::PH_NEWLINE;
				end else begin
					role = trp_pkg::ROLE_KEY;
					phase = trp_pkg::PH_STRING;
					note(trp_pkg::EV_KEY, b, 3'd0, 1'b0);
				end
			end
			trp_pkg::PH_NEWLINE: begin
				if (b != trp_pkg::CH_NEWLINE) begin
					raise(trp_pkg::ERR_CHAR, b);
				end else begin
					phase = trp_pkg::PH_CODE;
					note(trp_pkg::EV_RECEND, 8'd0, 3'd0, closing);
					if (closing) begin
						finished = 1'b1;
						closing = 1'b0;
					end
				end
			end
			default: raise(trp_pkg::ERR_CHAR, b);
		endcase
	endtask

	task automatic put(input logic [7:0] b);
		byte_stream.push_back(b);
	endtask

	// A string with random literal bytes and escapes, closed by a space.
	task automatic put_string();
		int len;
		logic [7:0] c;
		len = $urandom_range(0, 5);
		repeat (len) begin
			if ($urandom_range(0, 9) < 2) begin
				put(trp_pkg::CH_ESCAPE);
				put(hex_char(4'($urandom_range(0, 15))));
				put(hex_char(4'($urandom_range(0, 15))));
			end else begin
				do
					c = 8'($urandom_range(0, 255));
				while (c == trp_pkg::CH_SPACE || c == trp_pkg::CH_ESCAPE);
				put(c);
			end
		end
		put(trp_pkg::CH_SPACE);
	endtask

	task automatic put_record(input logic [7:0] code);
		int pairs;
		int r;
		logic [7:0] c;
		put(code);
		if (code == trp_pkg::CH_ENTER || code == trp_pkg::CH_NODE) begin
			put_string();
			put(trp_pkg::CH_OPEN);
			pairs = $urandom_range(0, 3);
			repeat (pairs) begin
				// The first key byte is literal, so a space or an escape mark is legal here.
				r = $urandom_range(0, 3);
				if (r == 0) begin
					put(trp_pkg::CH_SPACE);
				end else if (r == 1) begin
					put(trp_pkg::CH_ESCAPE);
				end else begin
					do
						c = 8'($urandom_range(0, 255));
					while (c == trp_pkg::CH_CLOSE);
					put(c);
				end
				put_string();
				put_string();
			end
			put(trp_pkg::CH_CLOSE);
		end
		put(trp_pkg::CH_NEWLINE);
	endtask

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0h got %0h", $time, what, want, got);
			mismatches++;
		end
	endtask

	// Stimulus: inputs move on the falling edge only.
	always @(negedge clk) begin : driver
		int mode;
		mode = (accepted_bytes / 128) % 4;
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_stall <= 1'b0;
		end else begin
			out_stall <= !draining &&
				($urandom_range(0, 99) < (mode == 2 ? 52 : (mode == 3 ? 29 : 0)));
			if (!in_valid || byte_taken) begin
				if (byte_stream.size() != 0 &&
						$urandom_range(0, 99) >= (mode == 1 ? 52 : (mode == 3 ? 29 : 0))) begin
					in_valid <= 1'b1;
					in_byte <= byte_stream.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		parse_event_t e;
		if (!arst_n) begin
			byte_taken <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_events.size() == 0) begin
					$display("%0t: event %0d with none expected", $time, event_res);
					mismatches++;
				end else begin
					e = pending_events.pop_front();
					check_field("event_res", e.ev, event_res);
					check_field("record_kind", e.kind, record_kind);
					check_field("data_byte", e.data, data_byte);
					check_field("error_code", e.err, error_code);
					check_field("tree_done", e.done, tree_done);
					check_field("nesting_depth", e.depth, nesting_depth);
				end
			end
			byte_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				accepted_bytes++;
				parse_byte(in_byte);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > cycle_limit) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		ending_t ending;
		int r;
		int gen_depth;
		int ceiling;
		int k;
		logic [7:0] b;
		logic [4:0] h;

		r = $urandom_range(0, 11);
		ending = (r < 5) ? END_TREE : ending_t'(r - 4);

		for (int i = 0; i < trp_pkg::HDR_LEN; i++)
			put(HEADER_BYTES[i]);
		if (ending == END_BAD_HEADER) begin
			k = $urandom_range(0, trp_pkg::HDR_LEN - 1);
			byte_stream[k] = HEADER_BYTES[k] ^ 8'($urandom_range(1, 255));
		end

		// Leave from depth zero, then an enter with escapes at both byte extremes and a
		// first key byte that is an escape mark taken literally.
		put(trp_pkg::CH_LEAVE);
		put(trp_pkg::CH_NEWLINE);
		put(trp_pkg::CH_ENTER);
		put(trp_pkg::CH_ESCAPE);
		put(8'h30);
		put(8'h30);
		put(8'hff);
		put(trp_pkg::CH_SPACE);
		put(trp_pkg::CH_OPEN);
		put(trp_pkg::CH_ESCAPE);
		put(8'h61);
		put(trp_pkg::CH_SPACE);
		put(trp_pkg::CH_ESCAPE);
		put(8'h66);
		put(8'h66);
		put(trp_pkg::CH_SPACE);
		put(trp_pkg::CH_CLOSE);
		put(trp_pkg::CH_NEWLINE);
		gen_depth = 0;

		// A leave at depth one would close the tree, so it is kept for the ending.
		ceiling = (ending == END_DEPTH_LOW) ? 0 : 12;
		while (byte_stream.size() < 700) begin
			r = $urandom_range(0, 9);
			if (r < 3 && gen_depth < ceiling) begin
				put_record(trp_pkg::CH_ENTER);
				gen_depth++;
			end else if (r < 6 && (gen_depth > 1 || (gen_depth <= 0 && r == 5))) begin
				put_record(trp_pkg::CH_LEAVE);
				gen_depth--;
			end else if (r < 8) begin
				put_record(trp_pkg::CH_NODE);
			end else begin
				put_record(trp_pkg::CH_MARK);
			end
		end

		case (ending)
			END_TREE: begin
				while (gen_depth < 1) begin
					put_record(trp_pkg::CH_ENTER);
					gen_depth++;
				end
				while (gen_depth > 1) begin
					put_record(trp_pkg::CH_LEAVE);
					gen_depth--;
				end
				put_record(trp_pkg::CH_LEAVE);
			end
			END_BAD_CODE: begin
				do
					b = 8'($urandom_range(0, 255));
				while (b inside {trp_pkg::CH_ENTER, trp_pkg::CH_NODE,
						trp_pkg::CH_MARK, trp_pkg::CH_LEAVE});
				put(b);
			end
			END_BAD_BRACKET: begin
				put(trp_pkg::CH_NODE);
				put_string();
				do
					b = 8'($urandom_range(0, 255));
				while (b == trp_pkg::CH_OPEN);
				put(b);
			end
			END_BAD_NEWLINE: begin
				put(trp_pkg::CH_MARK);
				do
					b = 8'($urandom_range(0, 255));
				while (b == trp_pkg::CH_NEWLINE);
				put(b);
			end
			END_BAD_HEX: begin
				put(trp_pkg::CH_NODE);
				put(trp_pkg::CH_ESCAPE);
				if ($urandom_range(0, 1))
					put(hex_char(4'($urandom_range(0, 15))));
				do begin
					b = 8'($urandom_range(0, 255));
					h = hex_nibble(b);
				end while (!h[4]);
				put(b);
			end
			END_DEPTH_HIGH: begin
				while (gen_depth < int'(NEST_MAX)) begin
					put(trp_pkg::CH_ENTER);
					put(trp_pkg::CH_SPACE);
					put(trp_pkg::CH_OPEN);
					put(trp_pkg::CH_CLOSE);
					put(trp_pkg::CH_NEWLINE);
					gen_depth++;
				end
				put(trp_pkg::CH_ENTER);
			end
			END_DEPTH_LOW: begin
				while (gen_depth > int'(NEST_MIN)) begin
					put(trp_pkg::CH_LEAVE);
					put(trp_pkg::CH_NEWLINE);
					gen_depth--;
				end
				put(trp_pkg::CH_LEAVE);
			end
			default: ;
		endcase
		// Whatever follows the end of the tree or an error must stay silent.
		repeat ($urandom_range(10, 40))
			put(8'($urandom_range(0, 255)));

		cycle_limit = 20 * byte_stream.size() + 20000;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_stream.size() != 0 || in_valid)
			@(posedge clk);
		draining = 1'b1;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (mismatches == 0 && pending_events.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
